// File: rtl/tcp_message_length_tracker_assert.svh
// Assertion macros used by the checker file.
`ifndef TCP_MESSAGE_LENGTH_TRACKER_ASSERT_SVH
`define TCP_MESSAGE_LENGTH_TRACKER_ASSERT_SVH

// Check a property outside reset.
`define TMLT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tmlt assertion failed");

// Check a property at every edge, reset included.
`define TMLT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tmlt assertion failed");

`endif

// File: rtl/tmlt_pkg.sv
package tmlt_pkg;

  // Default bound on recorded packets and message slots
  localparam int MAX_MESSAGES_DEF = 64;

  // Depth of the queues around the message engine
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_EMPTY = 1'd1;

  // Segment after classification, waiting for the message engine
  typedef struct packed {
    logic        en;
    logic        count_empty;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] payload;
    logic        short_segment;
    logic [31:0] ts_sec;
    logic [19:0] ts_usec;
  } tmlt_item_t;

  // One result item
  typedef struct packed {
    logic        pkt_recorded;
    logic [6:0]  pkt_count;
    logic [31:0] seq_delta;
    logic [31:0] ack_delta;
    logic [5:0]  msg_index;
    logic [31:0] msg_length;
    logic [31:0] msg_time_sec;
    logic [19:0] msg_time_usec;
    logic [6:0]  msg_count;
    logic        msg_table_full;
    logic        short_segment;
  } tmlt_result_t;

endpackage

// File: rtl/tmlt_fifo.sv
module tmlt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry on a push
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/tmlt_front.sv
module tmlt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tmlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmlt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [31:0]                    in_seq_number,
  input  logic [31:0]                    in_ack_number,
  input  logic [3:0]                     in_header_words,
  input  logic [15:0]                    in_segment_length,
  input  logic [31:0]                    in_ts_sec,
  input  logic [19:0]                    in_ts_usec,
  output tmlt_pkg::tmlt_item_t           item
);
  import tmlt_pkg::*;

  logic        enable_r, enable_nxt;
  logic        count_empty_r, count_empty_nxt;
  logic [15:0] hdr_bytes;

  // Decode configuration writes
  always_comb begin
    enable_nxt      = enable_r;
    count_empty_nxt = count_empty_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:      enable_nxt      = cfg_wdata[0];
        REG_COUNT_EMPTY: count_empty_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b1;
      count_empty_r <= 1'b0;
    end else begin
      enable_r      <= enable_nxt;
      count_empty_r <= count_empty_nxt;
    end
  end

  // Classify the segment: payload bytes and the short flag
  assign hdr_bytes = {10'd0, in_header_words, 2'b00};

  always_comb begin
    item.en            = enable_r;
    item.count_empty   = count_empty_r;
    item.seq_number    = in_seq_number;
    item.ack_number    = in_ack_number;
    item.ts_sec        = in_ts_sec;
    item.ts_usec       = in_ts_usec;
    item.short_segment = enable_r && (in_segment_length < hdr_bytes);
    if (in_segment_length < hdr_bytes) begin
      item.payload = '0;
    end else begin
      item.payload = in_segment_length - hdr_bytes;
    end
  end

endmodule

// File: rtl/tmlt_back.sv
module tmlt_back #(
  parameter int MAX_MESSAGES = tmlt_pkg::MAX_MESSAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tmlt_pkg::tmlt_item_t   item,
  input  logic                   item_valid,
  output logic                   item_pop,
  output tmlt_pkg::tmlt_result_t result,
  output logic                   result_push,
  input  logic                   result_full
);
  import tmlt_pkg::*;

  localparam int CNT_W = $clog2(MAX_MESSAGES + 1);

  logic [CNT_W-1:0] rec_cnt_r, rec_cnt_nxt;
  logic [31:0]      prev_seq_r, prev_seq_nxt;
  logic [31:0]      prev_ack_r, prev_ack_nxt;
  logic [CNT_W-1:0] msg_idx_r, msg_idx_nxt;
  logic [31:0]      msg_len_r, msg_len_nxt;
  logic [31:0]      msg_sec_r, msg_sec_nxt;
  logic [19:0]      msg_usec_r, msg_usec_nxt;
  logic [CNT_W-1:0] msg_cnt_r, msg_cnt_nxt;
  logic [31:0]      last_ack_r, last_ack_nxt;
  logic             tbl_full_r, tbl_full_nxt;

  logic             go;
  logic             rec;
  logic             adv;
  logic             use_seg;
  logic [31:0]      base_len;
  logic [32:0]      len_sum;
  logic [31:0]      dseq, dack;

  assign go          = item_valid && !result_full;
  assign item_pop    = go;
  assign result_push = go;

  // Work out the next state for the segment at the queue head
  always_comb begin
    rec_cnt_nxt  = rec_cnt_r;
    prev_seq_nxt = prev_seq_r;
    prev_ack_nxt = prev_ack_r;
    msg_idx_nxt  = msg_idx_r;
    msg_len_nxt  = msg_len_r;
    msg_sec_nxt  = msg_sec_r;
    msg_usec_nxt = msg_usec_r;
    msg_cnt_nxt  = msg_cnt_r;
    last_ack_nxt = last_ack_r;
    tbl_full_nxt = tbl_full_r;
    dseq         = '0;
    dack         = '0;
    adv          = (item.ack_number != last_ack_r) && (msg_len_r != '0);
    use_seg      = item.count_empty || (item.payload != '0);
    base_len     = adv ? '0 : msg_len_r;
    len_sum      = {1'b0, base_len} + 33'(item.payload);
    rec          = item.en && (rec_cnt_r < CNT_W'(MAX_MESSAGES));

    // Record seq and ack as deltas, for the first recorded segment as raw values
    if (rec) begin
      if (rec_cnt_r == '0) begin
        dseq = item.seq_number;
        dack = item.ack_number;
      end else begin
        dseq = item.seq_number - prev_seq_r;
        dack = item.ack_number - prev_ack_r;
      end
      prev_seq_nxt = item.seq_number;
      prev_ack_nxt = item.ack_number;
      rec_cnt_nxt  = rec_cnt_r + 1'b1;
    end

    // Group payload into messages
    if (item.en && !tbl_full_r) begin
      if (adv && (msg_idx_r == CNT_W'(MAX_MESSAGES - 1))) begin
        tbl_full_nxt = 1'b1;
      end else begin
        if (adv) begin
          msg_idx_nxt  = msg_idx_r + 1'b1;
          msg_len_nxt  = '0;
          msg_sec_nxt  = '0;
          msg_usec_nxt = '0;
        end
        if (use_seg) begin
          if ((base_len == '0) && (msg_cnt_r < CNT_W'(MAX_MESSAGES))) begin
            msg_cnt_nxt = msg_cnt_r + 1'b1;
          end
          msg_len_nxt  = len_sum[32] ? '1 : len_sum[31:0];
          msg_sec_nxt  = item.ts_sec;
          msg_usec_nxt = item.ts_usec;
        end
        last_ack_nxt = item.ack_number;
      end
    end
  end

  // Build the result from the updated state
  always_comb begin
    result.pkt_recorded   = rec;
    result.pkt_count      = 7'(rec_cnt_nxt);
    result.seq_delta      = dseq;
    result.ack_delta      = dack;
    result.msg_index      = 6'(msg_idx_nxt);
    result.msg_length     = msg_len_nxt;
    result.msg_time_sec   = msg_sec_nxt;
    result.msg_time_usec  = msg_usec_nxt;
    result.msg_count      = 7'(msg_cnt_nxt);
    result.msg_table_full = tbl_full_nxt;
    result.short_segment  = item.short_segment;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_cnt_r  <= '0;
      prev_seq_r <= '0;
      prev_ack_r <= '0;
      msg_idx_r  <= '0;
      msg_len_r  <= '0;
      msg_sec_r  <= '0;
      msg_usec_r <= '0;
      msg_cnt_r  <= '0;
      last_ack_r <= '0;
      tbl_full_r <= 1'b0;
    end else if (go) begin
      rec_cnt_r  <= rec_cnt_nxt;
      prev_seq_r <= prev_seq_nxt;
      prev_ack_r <= prev_ack_nxt;
      msg_idx_r  <= msg_idx_nxt;
      msg_len_r  <= msg_len_nxt;
      msg_sec_r  <= msg_sec_nxt;
      msg_usec_r <= msg_usec_nxt;
      msg_cnt_r  <= msg_cnt_nxt;
      last_ack_r <= last_ack_nxt;
      tbl_full_r <= tbl_full_nxt;
    end
  end

endmodule

// File: rtl/tcp_message_length_tracker.sv
// TCP message length tracker: takes one TCP segment of a flow per transfer and returns
// one result per segment, grouping payload bytes into messages by acknowledgement number
// and reporting seq/ack deltas for the first MAX_MESSAGES segments. Sustained rate is one
// segment per cycle while the result queue is not full; the engine takes each segment
// from the item queue and pushes its result to the result queue for the out_ ports.
// The rate is set by the message engine, which updates all per-flow state at once.
// Two-entry queues in front of and behind the engine let the input and result sides
// stall independently. Write configuration only while no results are outstanding.
module tcp_message_length_tracker #(
  parameter int MAX_MESSAGES = tmlt_pkg::MAX_MESSAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tmlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmlt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           push,
  output logic                           full,
  input  logic [31:0]                    in_seq_number,
  input  logic [31:0]                    in_ack_number,
  input  logic [3:0]                     in_header_words,
  input  logic [15:0]                    in_segment_length,
  input  logic [31:0]                    in_ts_sec,
  input  logic [19:0]                    in_ts_usec,
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_pkt_recorded,
  output logic [6:0]                     out_pkt_count,
  output logic [31:0]                    out_seq_delta,
  output logic [31:0]                    out_ack_delta,
  output logic [5:0]                     out_msg_index,
  output logic [31:0]                    out_msg_length,
  output logic [31:0]                    out_msg_time_sec,
  output logic [19:0]                    out_msg_time_usec,
  output logic [6:0]                     out_msg_count,
  output logic                           out_msg_table_full,
  output logic                           out_short_segment
);
  import tmlt_pkg::*;

  tmlt_item_t   front_item;
  tmlt_item_t   head_item;
  logic         item_empty;
  logic         item_pop;
  tmlt_result_t eng_result;
  tmlt_result_t out_result;
  logic         result_push;
  logic         result_full;

  // Classify incoming segments and hold configuration
  tmlt_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_seq_number     (in_seq_number),
    .in_ack_number     (in_ack_number),
    .in_header_words   (in_header_words),
    .in_segment_length (in_segment_length),
    .in_ts_sec         (in_ts_sec),
    .in_ts_usec        (in_ts_usec),
    .item              (front_item)
  );

  // Queue classified segments for the engine
  tmlt_fifo #(
    .WIDTH ($bits(tmlt_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (item_pop),
    .rdata (head_item),
    .empty (item_empty)
  );

  // Update message state one segment per cycle while the result queue has room
  tmlt_back #(
    .MAX_MESSAGES (MAX_MESSAGES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (head_item),
    .item_valid  (!item_empty),
    .item_pop    (item_pop),
    .result      (eng_result),
    .result_push (result_push),
    .result_full (result_full)
  );

  // Hold results until the consumer takes them
  tmlt_fifo #(
    .WIDTH ($bits(tmlt_result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (result_push),
    .wdata (eng_result),
    .full  (result_full),
    .pop   (pop),
    .rdata (out_result),
    .empty (empty)
  );

  assign out_pkt_recorded   = out_result.pkt_recorded;
  assign out_pkt_count      = out_result.pkt_count;
  assign out_seq_delta      = out_result.seq_delta;
  assign out_ack_delta      = out_result.ack_delta;
  assign out_msg_index      = out_result.msg_index;
  assign out_msg_length     = out_result.msg_length;
  assign out_msg_time_sec   = out_result.msg_time_sec;
  assign out_msg_time_usec  = out_result.msg_time_usec;
  assign out_msg_count      = out_result.msg_count;
  assign out_msg_table_full = out_result.msg_table_full;
  assign out_short_segment  = out_result.short_segment;

endmodule

// File: rtl/tmlt_checker.sv
`include "tcp_message_length_tracker_assert.svh"

module tmlt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic        out_pkt_recorded,
  input logic [6:0]  out_pkt_count,
  input logic [31:0] out_seq_delta,
  input logic [31:0] out_ack_delta
);

  // Reset drains the result queue
  `TMLT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty)

  // A recorded packet implies a nonzero packet count
  `TMLT_ASSERT(a_rec_count, (!empty && out_pkt_recorded) |-> (out_pkt_count != 7'd0))

  // Unrecorded packets carry zero deltas
  `TMLT_ASSERT(a_unrec_delta,
    (!empty && !out_pkt_recorded) |-> (out_seq_delta == 32'd0 && out_ack_delta == 32'd0))

  // A result not taken stays put
  `TMLT_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(out_seq_delta)))

endmodule

bind tcp_message_length_tracker tmlt_checker u_tmlt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .empty            (empty),
  .pop              (pop),
  .out_pkt_recorded (out_pkt_recorded),
  .out_pkt_count    (out_pkt_count),
  .out_seq_delta    (out_seq_delta),
  .out_ack_delta    (out_ack_delta)
);

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import tmlt_pkg::*;

  localparam int unsigned MAX_MESSAGES = MAX_MESSAGES_DEF;

  // One TCP segment as it is presented on the in_ ports
  typedef struct packed {
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [3:0]  header_words;
    logic [15:0] segment_length;
    logic [31:0] ts_sec;
    logic [19:0] ts_usec;
  } segment_t;

  typedef enum int {
    SEG_NOISE,
    SEG_SHORT,
    SEG_EMPTY,
    SEG_DATA,
    SEG_JUMBO
  } seg_kind_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic        push;
  logic        full;
  logic [31:0] in_seq_number;
  logic [31:0] in_ack_number;
  logic [3:0]  in_header_words;
  logic [15:0] in_segment_length;
  logic [31:0] in_ts_sec;
  logic [19:0] in_ts_usec;
  logic        empty;
  logic        pop;
  logic        out_pkt_recorded;
  logic [6:0]  out_pkt_count;
  logic [31:0] out_seq_delta;
  logic [31:0] out_ack_delta;
  logic [5:0]  out_msg_index;
  logic [31:0] out_msg_length;
  logic [31:0] out_msg_time_sec;
  logic [19:0] out_msg_time_usec;
  logic [6:0]  out_msg_count;
  logic        out_msg_table_full;
  logic        out_short_segment;

  tcp_message_length_tracker u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .push              (push),
    .full              (full),
    .in_seq_number     (in_seq_number),
    .in_ack_number     (in_ack_number),
    .in_header_words   (in_header_words),
    .in_segment_length (in_segment_length),
    .in_ts_sec         (in_ts_sec),
    .in_ts_usec        (in_ts_usec),
    .empty             (empty),
    .pop               (pop),
    .out_pkt_recorded  (out_pkt_recorded),
    .out_pkt_count     (out_pkt_count),
    .out_seq_delta     (out_seq_delta),
    .out_ack_delta     (out_ack_delta),
    .out_msg_index     (out_msg_index),
    .out_msg_length    (out_msg_length),
    .out_msg_time_sec  (out_msg_time_sec),
    .out_msg_time_usec (out_msg_time_usec),
    .out_msg_count     (out_msg_count),
    .out_msg_table_full(out_msg_table_full),
    .out_short_segment (out_short_segment)
  );

  // Tracker state mirrored by the predictor
  logic        en_reg = 1'b1;
  logic        ce_reg = 1'b0;
  int unsigned rec_count = 0;
  logic [31:0] prev_seq = '0;
  logic [31:0] prev_ack = '0;
  int unsigned msg_idx = 0;
  logic [31:0] msg_len = '0;
  logic [31:0] msg_sec = '0;
  logic [19:0] msg_usec = '0;
  int unsigned msg_cnt = 0;
  logic [31:0] last_ack = '0;
  logic        tbl_full = 1'b0;

  tmlt_result_t expected_results[$];
  int unsigned  error_count = 0;
  bit           idle_on = 1'b1;

  // Flow generator state
  logic [31:0] flow_seq;
  logic [31:0] flow_ack;
  logic [31:0] flow_sec;
  int unsigned flow_usec;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the tracker state by one segment and return the result it produces
  function automatic tmlt_result_t track_segment(input segment_t s);
    tmlt_result_t r;
    logic [31:0]  hdr_bytes;
    logic [31:0]  payload;
    logic         store;
    r = '0;
    if (en_reg) begin
      hdr_bytes = {26'd0, s.header_words, 2'b00};
      if (rec_count < MAX_MESSAGES) begin
        r.pkt_recorded = 1'b1;
        if (rec_count == 0) begin
          r.seq_delta = s.seq_number;
          r.ack_delta = s.ack_number;
        end else begin
          r.seq_delta = s.seq_number - prev_seq;
          r.ack_delta = s.ack_number - prev_ack;
        end
        prev_seq = s.seq_number;
        prev_ack = s.ack_number;
        rec_count++;
      end
      if ({16'd0, s.segment_length} < hdr_bytes) begin
        payload = '0;
        r.short_segment = 1'b1;
      end else begin
        payload = {16'd0, s.segment_length} - hdr_bytes;
      end
      if (!tbl_full) begin
        store = 1'b1;
        // Open a new message on an ack change once the current one holds bytes
        if (s.ack_number != last_ack && msg_len != 0) begin
          if (msg_idx + 1 >= MAX_MESSAGES) begin
            tbl_full = 1'b1;
            store = 1'b0;
          end else begin
            msg_idx++;
            msg_len = '0;
            msg_sec = '0;
            msg_usec = '0;
          end
        end
        if (store) begin
          if (ce_reg || payload != 0) begin
            if (msg_len == 0 && msg_cnt < MAX_MESSAGES) msg_cnt++;
            if (msg_len > 32'hFFFF_FFFF - payload) msg_len = 32'hFFFF_FFFF;
            else msg_len = msg_len + payload;
            msg_sec = s.ts_sec;
            msg_usec = s.ts_usec;
          end
          last_ack = s.ack_number;
        end
      end
    end
    r.pkt_count      = 7'(rec_count);
    r.msg_index      = 6'(msg_idx);
    r.msg_length     = msg_len;
    r.msg_time_sec   = msg_sec;
    r.msg_time_usec  = msg_usec;
    r.msg_count      = 7'(msg_cnt);
    r.msg_table_full = tbl_full;
    return r;
  endfunction

  function automatic seg_kind_t random_kind();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0:       return SEG_NOISE;
      1:       return SEG_SHORT;
      2, 3:    return SEG_EMPTY;
      4:       return SEG_JUMBO;
      default: return SEG_DATA;
    endcase
  endfunction

  // Build the next segment of the flow; noise ignores the flow entirely
  function automatic segment_t make_segment(input logic [31:0] ack, input seg_kind_t kind);
    segment_t    s;
    int unsigned pay;
    int unsigned hbytes;
    pay = 0;
    s.header_words = 4'($urandom_range(0, 15));
    hbytes = 4 * s.header_words;
    s.ack_number = ack;
    case (kind)
      SEG_SHORT: begin
        s.header_words = 4'($urandom_range(1, 15));
        s.segment_length = 16'($urandom_range(0, 4 * s.header_words - 1));
      end
      SEG_EMPTY: s.segment_length = 16'(hbytes);
      SEG_JUMBO: begin
        pay = $urandom_range(1, 65535 - hbytes);
        s.segment_length = 16'(hbytes + pay);
      end
      SEG_DATA: begin
        pay = $urandom_range(1, 1460);
        s.segment_length = 16'(hbytes + pay);
      end
      default: s.segment_length = 16'($urandom);
    endcase
    if (kind == SEG_NOISE) begin
      s.seq_number = $urandom;
      s.ack_number = $urandom;
      s.ts_sec = $urandom;
      s.ts_usec = 20'($urandom_range(0, 999999));
    end else begin
      s.seq_number = flow_seq;
      flow_seq = flow_seq + pay;
      flow_usec = flow_usec + $urandom_range(0, 300000);
      if (flow_usec > 999999) begin
        flow_usec = flow_usec - 1000000;
        flow_sec = flow_sec + 1;
      end
      s.ts_sec = flow_sec;
      s.ts_usec = 20'(flow_usec);
    end
    return s;
  endfunction

  // Present one segment, hold it until the transfer, then record its expected result
  task automatic send_segment(input segment_t s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push              <= 1'b1;
    in_seq_number     <= s.seq_number;
    in_ack_number     <= s.ack_number;
    in_header_words   <= s.header_words;
    in_segment_length <= s.segment_length;
    in_ts_sec         <= s.ts_sec;
    in_ts_usec        <= s.ts_usec;
    do @(posedge clk); while (full);
    expected_results.push_back(track_segment(s));
  endtask

  // Stop sending and wait until every expected result has been popped
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic configure(input logic en, input logic ce);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENABLE;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_index <= REG_COUNT_EMPTY;
    cfg_wdata <= ce;
    @(posedge clk);
    cfg_we <= 1'b0;
    en_reg = en;
    ce_reg = ce;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_result();
    tmlt_result_t exp_r;
    if (expected_results.size() == 0) begin
      error_count++;
      $display("%0t: result with none expected, expected none actual index %0h length %0h",
               $time, out_msg_index, out_msg_length);
      return;
    end
    exp_r = expected_results.pop_front();
    check_field("pkt_recorded", exp_r.pkt_recorded, out_pkt_recorded);
    check_field("pkt_count", exp_r.pkt_count, out_pkt_count);
    check_field("seq_delta", exp_r.seq_delta, out_seq_delta);
    check_field("ack_delta", exp_r.ack_delta, out_ack_delta);
    check_field("msg_index", exp_r.msg_index, out_msg_index);
    check_field("msg_length", exp_r.msg_length, out_msg_length);
    check_field("msg_time_sec", exp_r.msg_time_sec, out_msg_time_sec);
    check_field("msg_time_usec", exp_r.msg_time_usec, out_msg_time_usec);
    check_field("msg_count", exp_r.msg_count, out_msg_count);
    check_field("msg_table_full", exp_r.msg_table_full, out_msg_table_full);
    check_field("short_segment", exp_r.short_segment, out_short_segment);
  endtask

  // Pop results with random stalls and check each transfer
  initial begin : result_monitor
    int unsigned stall_left;
    stall_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (pop && !empty) check_result();
        if (stall_left > 0) begin
          stall_left--;
          pop <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 14) - 1;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  // Field extremes, short and exact headers, first recorded and wrapping deltas
  task automatic test_directed();
    configure(1'b1, 1'b0);
    send_segment('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 16'hFFFF, 32'hFFFF_FFFF, 20'd999999});
    send_segment('{32'h0, 32'h0, 4'd0, 16'd0, 32'h0, 20'd0});
    send_segment('{32'h1, 32'h0, 4'd5, 16'd19, 32'h10, 20'd1});
    send_segment('{32'h1, 32'h0, 4'd5, 16'd20, 32'h10, 20'd2});
    send_segment('{32'h1, 32'h0, 4'd5, 16'd21, 32'h0, 20'd0});
    send_segment('{32'h2, 32'h1, 4'd0, 16'd1, 32'h11, 20'd500000});
    send_segment('{32'h3, 32'h1, 4'd0, 16'hFFFF, 32'h0, 20'd0});
    send_segment('{32'h1_0002, 32'h2, 4'd15, 16'd0, 32'h12, 20'd7});
    send_segment('{32'h1_0002, 32'h3, 4'd5, 16'd100, 32'h13, 20'd999999});
  endtask

  // Zero-payload segments open and update messages when counting empties
  task automatic test_count_empty();
    configure(1'b1, 1'b1);
    repeat (8)
      send_segment('{32'h1_0100, 32'h100, 4'd5, 16'd20, 32'h20, 20'($urandom_range(0, 999999))});
    send_segment('{32'h1_0100, 32'h101, 4'd6, 16'd24, 32'h21, 20'd3});
    send_segment('{32'h1_0100, 32'h101, 4'd5, 16'd60, 32'h22, 20'd4});
    send_segment('{32'h1_0128, 32'h102, 4'd8, 16'd32, 32'h23, 20'd5});
  endtask

  // Disabled: state holds, recording fields read zero
  task automatic test_disabled();
    configure(1'b0, 1'b1);
    send_segment('{32'h5555_5555, 32'hAAAA_AAAA, 4'd15, 16'd3, 32'h30, 20'd6});
    send_segment('{32'hAAAA_AAAA, 32'h5555_5555, 4'd0, 16'd1000, 32'h31, 20'd7});
    send_segment('{32'h0, 32'h0, 4'd5, 16'd20, 32'h32, 20'd8});
  endtask

  // Pile full-size payloads back to back into one message for a large length sum
  task automatic test_long_message();
    configure(1'b1, 1'b0);
    idle_on = 1'b0;
    flow_ack = flow_ack + 1;
    repeat (40)
      send_segment('{flow_seq, flow_ack, 4'd0, 16'hFFFF, flow_sec, 20'(flow_usec)});
    drain_results();
    idle_on = 1'b1;
  endtask

  // Bursts of segments sharing an ack, with noise and broken segments mixed in
  task automatic run_random_phase(input int unsigned n_items, input logic en, input logic ce);
    int unsigned sent;
    int unsigned burst;
    configure(en, ce);
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 16);
      case ($urandom_range(0, 7))
        0:       ;
        1:       flow_ack = $urandom;
        default: flow_ack = flow_ack + $urandom_range(1, 4000);
      endcase
      repeat (burst) begin
        send_segment(make_segment(flow_ack, random_kind()));
        sent++;
      end
      if ($urandom_range(0, 31) == 0) drain_results();
    end
    drain_results();
  endtask

  // Force message advances until the index hits its bound, then check that state freezes
  task automatic test_table_full();
    int unsigned guard;
    configure(1'b1, 1'b0);
    idle_on = 1'b0;
    guard = 0;
    while (!tbl_full && guard < 200) begin
      flow_ack = flow_ack + 1;
      send_segment(make_segment(flow_ack, SEG_DATA));
      guard++;
    end
    repeat (24) begin
      flow_ack = flow_ack + $urandom_range(0, 1);
      send_segment(make_segment(flow_ack, random_kind()));
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_ENABLE;
    cfg_wdata         <= '0;
    push              <= 1'b0;
    in_seq_number     <= '0;
    in_ack_number     <= '0;
    in_header_words   <= '0;
    in_segment_length <= '0;
    in_ts_sec         <= '0;
    in_ts_usec        <= '0;
    flow_seq  = $urandom;
    flow_ack  = $urandom;
    flow_sec  = $urandom_range(0, 100000);
    flow_usec = $urandom_range(0, 999999);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_count_empty();
    test_disabled();
    test_long_message();
    run_random_phase(120, 1'b1, 1'b0);
    run_random_phase(120, 1'b1, 1'b1);
    run_random_phase(30, 1'b0, 1'b1);
    run_random_phase(180, 1'b1, 1'b0);
    test_table_full();

    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Bound the run in case the block hangs
  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
